// ----- src/plsg_pkg.sv -----
// plsg_pkg: widths, register codes and shared types of the piecewise-linear seed generator
// depends on nothing; every other file of the block imports it
`default_nettype none

package plsg_pkg;

    // field widths
    localparam int POS_W   = 20;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int FRAC_W  = 16;
    localparam int WGT_W   = FRAC_W + 1;
    localparam int DIFF_W  = POS_W + 1;
    localparam int DIVD_W  = WGT_W + FRAC_W;
    localparam int DCNT_W  = 5;

    // run length limits
    localparam int MAX_SUPPORT = 64;
    localparam int RUN_CAP     = (MAX_SUPPORT < 64) ? MAX_SUPPORT : 64;

    // apb register map
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_POINT_COUNT   = 2'd0,
        REG_VIA_ENABLE    = 2'd1,
        REG_VIA_FRACTION  = 2'd2
    } reg_idx_t;

    localparam logic [CNT_W-1:0]  POINT_COUNT_RST   = 7'd2;
    localparam logic [FRAC_W-1:0] VIA_FRACTION_RST  = 16'd32768;

    // configuration seen by the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]  point_count;
        logic              via_enable;
        logic [FRAC_W-1:0] via_fraction;
    } cfg_t;

    // divider request and status
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [FRAC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WGT_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- src/plsg_if.sv -----
// plsg_if: valid/ready channel interfaces for the request and result streams
// depends on plsg_pkg
`default_nettype none

interface plsg_in_if;
    import plsg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] start_pos;
    logic signed [POS_W-1:0] end_pos;
    logic signed [POS_W-1:0] via_pos;

    modport source (output valid, start_pos, end_pos, via_pos, input ready);
    modport sink   (input valid, start_pos, end_pos, via_pos, output ready);
endinterface

interface plsg_out_if;
    import plsg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] position;
    logic [IDX_W-1:0]        step_index;
    logic                    last;

    modport source (output valid, position, step_index, last, input ready);
    modport sink   (input valid, position, step_index, last, output ready);
endinterface

`default_nettype wire

// ----- src/plsg_regs.sv -----
// plsg_regs: apb configuration registers (point count, via enable, via fraction)
// depends on plsg_pkg
`default_nettype none

module plsg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [plsg_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [plsg_pkg::APB_DW-1:0]     pwdata,
    output logic      [plsg_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    output plsg_pkg::cfg_t                       cfg
);
    import plsg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel_idx;
    logic     wr_en;

    assign sel_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel_idx)
                REG_POINT_COUNT:   cfg_next.point_count   = pwdata[CNT_W-1:0];
                REG_VIA_ENABLE:    cfg_next.via_enable    = pwdata[0];
                REG_VIA_FRACTION:  cfg_next.via_fraction  = pwdata[FRAC_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.point_count   <= POINT_COUNT_RST;
            cfg_reg.via_enable    <= 1'b0;
            cfg_reg.via_fraction  <= VIA_FRACTION_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (sel_idx)
            REG_POINT_COUNT:   prdata = {{(APB_DW-CNT_W){1'b0}}, cfg_reg.point_count};
            REG_VIA_ENABLE:    prdata = {{(APB_DW-1){1'b0}}, cfg_reg.via_enable};
            REG_VIA_FRACTION:  prdata = {{(APB_DW-FRAC_W){1'b0}}, cfg_reg.via_fraction};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/plsg_div.sv -----
// plsg_div: shared radix-2 restoring divider, one quotient bit per cycle, 17 steps, then done
// depends on plsg_pkg; quotient must fit in 17 bits (dividend < divisor * 2^17)
`default_nettype none

module plsg_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire plsg_pkg::div_req_t  req,
    output plsg_pkg::div_stat_t      stat
);
    import plsg_pkg::*;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [DCNT_W-1:0] cnt_reg,   cnt_next;
    logic [FRAC_W-1:0] rem_reg,   rem_next;
    logic [WGT_W-1:0]  dlo_reg,   dlo_next;
    logic [WGT_W-1:0]  q_reg,     q_next;
    logic [FRAC_W-1:0] dvs_reg,   dvs_next;
    logic [WGT_W-1:0]  trial_rem;
    logic [WGT_W:0]    trial_sub;

    // one trial subtraction per cycle
    assign trial_rem = {rem_reg, dlo_reg[WGT_W-1]};
    assign trial_sub = {1'b0, trial_rem} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dlo_next  = dlo_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend[DIVD_W-1:WGT_W];
            dlo_next  = req.dividend[WGT_W-1:0];
            dvs_next  = req.divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!trial_sub[WGT_W])
            begin
                rem_next = trial_sub[FRAC_W-1:0];
                q_next   = {q_reg[WGT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial_rem[FRAC_W-1:0];
                q_next   = {q_reg[WGT_W-2:0], 1'b0};
            end
            dlo_next = {dlo_reg[WGT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(WGT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dlo_reg  <= '0;
            q_reg    <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            dlo_reg  <= dlo_next;
            q_reg    <= q_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = q_reg;

`ifndef NO_ASSERTIONS
    // done follows the final step of a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    // step counter never passes the quotient width while busy
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < DCNT_W'(WGT_W)))
        else $error("divider step count out of range");

    // a division started while idle reports done after its final quotient step
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req.start && !busy_reg) |=> ##17 done_reg)
        else $error("divider latency wrong");
`endif

endmodule

`default_nettype wire

// ----- src/plsg_seq.sv -----
// plsg_seq: run sequencer; drives the shared divider, the blend multiplier and the result register
// depends on plsg_pkg, plsg_if
`default_nettype none

module plsg_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire plsg_pkg::cfg_t     cfg,
    plsg_in_if.sink                 in_ch,
    plsg_out_if.source              out_ch,
    output plsg_pkg::div_req_t      div_req,
    input  wire plsg_pkg::div_stat_t div_stat
);
    import plsg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_U,
        ST_DIV_W,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t                   state_reg,    state_next;
    logic [IDX_W-1:0]         step_reg,     step_next;
    logic [IDX_W-1:0]         nm1_reg,      nm1_next;
    logic signed [POS_W-1:0]  start_reg,    start_next;
    logic signed [POS_W-1:0]  end_reg,      end_next;
    logic signed [POS_W-1:0]  via_reg,      via_next;
    logic signed [POS_W-1:0]  a_reg,        a_next;
    logic signed [DIFF_W-1:0] diff_reg,     diff_next;
    logic [WGT_W-1:0]         w_reg,        w_next;
    logic [POS_W-1:0]         sh_reg,       sh_next;
    logic                     oval_reg,     oval_next;
    logic [POS_W-1:0]         opos_reg,     opos_next;
    logic [IDX_W-1:0]         oidx_reg,     oidx_next;
    logic                     olast_reg,    olast_next;

    logic [IDX_W-1:0]         nm1_cfg;
    logic [FRAC_W-1:0]        frac_eff;
    logic [FRAC_W-1:0]        frac_rest;
    logic [WGT_W-1:0]         u_q;
    logic [WGT_W-1:0]         u_minus_f;
    logic signed [DIFF_W+WGT_W:0] mul_full;
    logic                     slot_free;
    logic                     is_last;

    // effective run length minus one and via fraction
    always_comb
    begin
        if (cfg.point_count < CNT_W'(2))
            nm1_cfg = IDX_W'(1);
        else if (cfg.point_count > CNT_W'(RUN_CAP))
            nm1_cfg = IDX_W'(RUN_CAP - 1);
        else
            nm1_cfg = IDX_W'(cfg.point_count - 1'b1);
    end

    assign frac_eff  = (cfg.via_fraction == '0) ? FRAC_W'(1) : cfg.via_fraction;
    assign frac_rest = FRAC_W'(18'd65536 - {2'b00, frac_eff});
    assign u_q       = div_stat.quotient;
    assign u_minus_f = u_q - {1'b0, frac_eff};

    // blend multiplier: (b - a) * w, scaled down by 2^16
    assign mul_full  = diff_reg * $signed({1'b0, w_reg});

    assign slot_free = !oval_reg || out_ch.ready;
    assign is_last   = (step_reg == nm1_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        nm1_next   = nm1_reg;
        start_next = start_reg;
        end_next   = end_reg;
        via_next   = via_reg;
        a_next     = a_reg;
        diff_next  = diff_reg;
        w_next     = w_reg;
        sh_next    = sh_reg;
        oval_next  = oval_reg;
        opos_next  = opos_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;

        // result register drains independently of the sequencer
        if (oval_reg && out_ch.ready)
            oval_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // latch the request and start the run fraction for step zero
                if (in_ch.valid)
                begin
                    start_next = in_ch.start_pos;
                    end_next   = in_ch.end_pos;
                    via_next   = in_ch.via_pos;
                    nm1_next   = nm1_cfg;
                    step_next  = '0;
                    div_req.start    = 1'b1;
                    div_req.dividend = '0;
                    div_req.divisor  = {{(FRAC_W-IDX_W){1'b0}}, nm1_cfg};
                    state_next = ST_DIV_U;
                end
            end
            ST_DIV_U:
            begin
                // run fraction ready: pick the segment and its local weight
                if (div_stat.done)
                begin
                    if (!cfg.via_enable)
                    begin
                        w_next     = u_q;
                        a_next     = start_reg;
                        diff_next  = DIFF_W'(end_reg) - DIFF_W'(start_reg);
                        state_next = ST_MUL;
                    end
                    else if (u_q <= {1'b0, frac_eff})
                    begin
                        a_next     = start_reg;
                        diff_next  = DIFF_W'(via_reg) - DIFF_W'(start_reg);
                        div_req.start    = 1'b1;
                        div_req.dividend = {u_q, {FRAC_W{1'b0}}};
                        div_req.divisor  = frac_eff;
                        state_next = ST_DIV_W;
                    end
                    else
                    begin
                        a_next     = via_reg;
                        diff_next  = DIFF_W'(end_reg) - DIFF_W'(via_reg);
                        div_req.start    = 1'b1;
                        div_req.dividend = {u_minus_f, {FRAC_W{1'b0}}};
                        div_req.divisor  = frac_rest;
                        state_next = ST_DIV_W;
                    end
                end
            end
            ST_DIV_W:
            begin
                if (div_stat.done)
                begin
                    w_next     = u_q;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                sh_next    = mul_full[35:16];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // load the result register, then the next step or back to idle
                if (slot_free)
                begin
                    oval_next  = 1'b1;
                    opos_next  = POS_W'(a_reg) + sh_reg;
                    oidx_next  = step_reg;
                    olast_next = is_last;
                    if (is_last)
                    begin
                        step_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = {{(DIVD_W-IDX_W-FRAC_W){1'b0}},
                                            step_reg + 1'b1, {FRAC_W{1'b0}}};
                        div_req.divisor  = {{(FRAC_W-IDX_W){1'b0}}, nm1_reg};
                        state_next = ST_DIV_U;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            nm1_reg   <= IDX_W'(1);
            start_reg <= '0;
            end_reg   <= '0;
            via_reg   <= '0;
            a_reg     <= '0;
            diff_reg  <= '0;
            w_reg     <= '0;
            sh_reg    <= '0;
            oval_reg  <= 1'b0;
            opos_reg  <= '0;
            oidx_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            nm1_reg   <= nm1_next;
            start_reg <= start_next;
            end_reg   <= end_next;
            via_reg   <= via_next;
            a_reg     <= a_next;
            diff_reg  <= diff_next;
            w_reg     <= w_next;
            sh_reg    <= sh_next;
            oval_reg  <= oval_next;
            opos_reg  <= opos_next;
            oidx_reg  <= oidx_next;
            olast_reg <= olast_next;
        end
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = oval_reg;
    assign out_ch.position   = opos_reg;
    assign out_ch.step_index = oidx_reg;
    assign out_ch.last       = olast_reg;

`ifndef NO_ASSERTIONS
    // the shared divider is never restarted mid-division
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // divider results only arrive while the sequencer waits for them
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV_U || state_reg == ST_DIV_W))
        else $error("divider result in wrong state");

    // loading the final result of a run returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && is_last) |=> in_ch.ready)
        else $error("run did not end after its final result");
`endif

endmodule

`default_nettype wire

// ----- src/piecewise_linear_seed_generator_top.sv -----
// piecewise_linear_seed_generator_top: top level of the seed generator
// depends on plsg_pkg, plsg_if, plsg_regs, plsg_div, plsg_seq
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+------------------------------------
//   in_ch    | in  | valid/ready         | start_pos, end_pos, via_pos (s20 q3.16)
//   out_ch   | out | valid/ready         | position (s20), step_index (6), last
//   apb      | in  | psel/penable/pready | point_count, via_enable, via_fraction
//
// each request yields n results, n = point_count clamped to 2..64
// each result takes one pass of the shared divider (17 quotient bits, then done)
// for the run fraction, a second for the local weight when the via point is on,
// then the multiply state and the emit state, which loads the result register
// the request port is ready only while idle; the result register lets the
// next request in while the final result waits, a stalled result holds the run
// rst_n clears control state and loads register reset values at once
`default_nettype none

module piecewise_linear_seed_generator_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [plsg_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [plsg_pkg::APB_DW-1:0]     pwdata,
    output logic      [plsg_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready,
    plsg_in_if.sink                              in_ch,
    plsg_out_if.source                           out_ch
);
    import plsg_pkg::*;

    cfg_t      cfg;
    div_req_t  div_req;
    div_stat_t div_stat;

    // configuration registers
    plsg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared divider
    plsg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // sequencer and blend datapath
    plsg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .div_req  (div_req),
        .div_stat (div_stat)
    );

endmodule

`default_nettype wire
